/* rtl/bkr_pkg.sv */
package bkr_pkg;

  localparam int ATT_W  = 8;
  localparam int INIT_W = 16;
  localparam int MULT_W = 12;
  localparam int CD_W   = 24;
  localparam int ACC_W  = 32;
  localparam int FRAC_W = 8;
  localparam int PROD_W = ACC_W + MULT_W;
  localparam int DEV_W  = 3;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_POLICY    = 3'd0;
  localparam logic [2:0] REG_MAX_ATT   = 3'd1;
  localparam logic [2:0] REG_INIT      = 3'd2;
  localparam logic [2:0] REG_MULT      = 3'd3;
  localparam logic [2:0] REG_MAX_DELAY = 3'd4;

  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_SCHEDULE   = 4'd1,
    OP_CANCEL     = 4'd2,
    OP_CANCEL_ALL = 4'd3,
    OP_PAUSE      = 4'd4,
    OP_RESUME     = 4'd5,
    OP_COMPLETE   = 4'd6,
    OP_RETRY      = 4'd7,
    OP_TERMINAL   = 4'd8,
    OP_QUERY      = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    EV_DUE       = 2'd0,
    EV_EXHAUSTED = 2'd1,
    EV_TERMINAL  = 2'd2,
    EV_STATUS    = 2'd3
  } ev_kind_e;

  typedef struct packed {
    logic              start;
    logic [ATT_W-1:0]  steps;
    logic [INIT_W-1:0] init;
    logic [MULT_W-1:0] mult;
    logic [CD_W-1:0]   cap;
  } dly_req_t;

  typedef struct packed {
    logic            done;
    logic [CD_W-1:0] delay;
  } dly_rsp_t;

endpackage

/* rtl/bkr_in_if.sv */
interface bkr_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [2:0] device;

  modport source (output valid, opcode, device, input ready);
  modport sink (input valid, opcode, device, output ready);
endinterface

/* rtl/bkr_out_if.sv */
interface bkr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [2:0] event_device;
  logic [7:0] attempt_count;
  logic       is_scheduled;
  logic       is_in_progress;
  logic       last_event;

  modport source (output valid, event_kind, event_device, attempt_count, is_scheduled,
                  is_in_progress, last_event, input ready);
  modport sink (input valid, event_kind, event_device, attempt_count, is_scheduled,
                is_in_progress, last_event, output ready);
endinterface

/* rtl/bkr_delay.sv */
module bkr_delay
  import bkr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dly_req_t req_i,
  output dly_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [ATT_W-1:0]  cnt_q;
  logic [ACC_W-1:0]  acc_q;
  logic [MULT_W-1:0] mult_q;
  logic [CD_W-1:0]   cap_q;
  logic [CD_W-1:0]   delay_q;

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-FRAC_W-1:0] shifted;
  logic [ACC_W-1:0]        acc_next;

  // one Q4.8 multiply per cycle, saturating at 32 bits
  always_comb begin
    prod     = PROD_W'(acc_q) * PROD_W'(mult_q);
    shifted  = prod[PROD_W-1:FRAC_W];
    acc_next = (|shifted[PROD_W-FRAC_W-1:ACC_W]) ? '1 : shifted[ACC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q  <= ACC_W'(req_i.init);
      cnt_q  <= req_i.steps;
      mult_q <= req_i.mult;
      cap_q  <= req_i.cap;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        delay_q <= (acc_q > ACC_W'(cap_q)) ? cap_q : acc_q[CD_W-1:0];
      end else begin
        acc_q <= acc_next;
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.delay = delay_q;

endmodule

/* rtl/backoff_reconnect_scheduler_top.sv */
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    opcode, device
// out_o     out  valid/ready    event_kind, event_device, attempt_count, status, last_event
// apb       in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
// One item at a time; ready only while the sequencer is idle.
// Tick: walks every slot, then scans the marked slots up to the last due one.
// Schedule/retry: runs the shared multiplier once per prior attempt.
// An output register lets the next item in while a result waits.
// Async active-low reset; no clearing pass, countdowns are written before use.
module backoff_reconnect_scheduler_top
  import bkr_pkg::*;
#(
  parameter int DEVICE_SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bkr_in_if.sink                in_i,
  bkr_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLOT_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEVICE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DSTART, S_DELAY, S_EMIT, S_WALK, S_DRAIN
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic [DEV_W-1:0] dev_q;
  logic             paused_q;

  logic              policy_q;
  logic [ATT_W-1:0]  max_att_q;
  logic [INIT_W-1:0] init_q;
  logic [MULT_W-1:0] mult_q;
  logic [CD_W-1:0]   max_delay_q;

  logic [DEVICE_SLOTS-1:0] present_q;
  logic [DEVICE_SLOTS-1:0] armed_q;
  logic [DEVICE_SLOTS-1:0] inflight_q;
  logic [DEVICE_SLOTS-1:0] mask_q;
  logic [ATT_W-1:0]        attempt_q [DEVICE_SLOTS];
  logic [CD_W-1:0]         cd_q [DEVICE_SLOTS];
  logic [SLOT_W-1:0]       idx_q;

  ev_kind_e         pend_kind_q;
  logic [ATT_W-1:0] pend_att_q;
  logic             pend_sch_q;
  logic             pend_prog_q;

  logic             out_valid_q;
  ev_kind_e         out_kind_q;
  logic [DEV_W-1:0] out_dev_q;
  logic [ATT_W-1:0] out_att_q;
  logic             out_sch_q;
  logic             out_prog_q;
  logic             out_last_q;

  logic              cfg_wr;
  logic [2:0]        reg_idx;
  logic [SLOT_W-1:0] sidx;
  logic              dev_ok;
  logic [ATT_W-1:0]  att_eff;
  logic              inflight_eff;
  logic              out_free;
  logic [DEVICE_SLOTS-1:0] idx_bit;

  logic              cd_we;
  logic [SLOT_W-1:0] cd_widx;
  logic [CD_W-1:0]   cd_wdata;

  dly_req_t dly_req;
  dly_rsp_t dly_rsp;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[4:2];
  assign pready   = 1'b1;
  assign sidx     = SLOT_W'(dev_q);
  assign dev_ok   = 32'(dev_q) < DEVICE_SLOTS;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_bit  = DEVICE_SLOTS'(1) << idx_q;

  assign att_eff = (op_q == OP_RETRY && attempt_q[sidx] != '0) ?
                   attempt_q[sidx] - 1'b1 : attempt_q[sidx];
  assign inflight_eff = (op_q == OP_RETRY) ? 1'b0 : inflight_q[sidx];

  always_comb begin
    case (reg_idx)
      REG_POLICY:    prdata = APB_DATA_W'(policy_q);
      REG_MAX_ATT:   prdata = APB_DATA_W'(max_att_q);
      REG_INIT:      prdata = APB_DATA_W'(init_q);
      REG_MULT:      prdata = APB_DATA_W'(mult_q);
      REG_MAX_DELAY: prdata = APB_DATA_W'(max_delay_q);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    dly_req.start = (state_q == S_DSTART);
    dly_req.steps = attempt_q[sidx] - 1'b1;
    dly_req.init  = init_q;
    dly_req.mult  = mult_q;
    dly_req.cap   = max_delay_q;
  end

  bkr_delay u_delay (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dly_req),
    .rsp_o  (dly_rsp)
  );

  // single write port into the countdown store
  always_comb begin
    cd_we    = 1'b0;
    cd_widx  = idx_q;
    cd_wdata = '0;
    if (state_q == S_WALK && armed_q[idx_q]) begin
      cd_we    = 1'b1;
      cd_wdata = (cd_q[idx_q] <= CD_W'(1)) ? '0 : cd_q[idx_q] - 1'b1;
    end else if (state_q == S_DELAY && dly_rsp.done) begin
      cd_we    = 1'b1;
      cd_widx  = sidx;
      cd_wdata = dly_rsp.delay;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_we) begin
      cd_q[cd_widx] <= cd_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_TICK;
      dev_q       <= '0;
      paused_q    <= 1'b0;
      policy_q    <= 1'b1;
      max_att_q   <= ATT_W'(5);
      init_q      <= INIT_W'(1000);
      mult_q      <= MULT_W'(512);
      max_delay_q <= CD_W'(30000);
      present_q   <= '0;
      armed_q     <= '0;
      inflight_q  <= '0;
      mask_q      <= '0;
      attempt_q   <= '{default: '0};
      idx_q       <= '0;
      pend_kind_q <= EV_DUE;
      pend_att_q  <= '0;
      pend_sch_q  <= 1'b0;
      pend_prog_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= EV_DUE;
      out_dev_q   <= '0;
      out_att_q   <= '0;
      out_sch_q   <= 1'b0;
      out_prog_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_POLICY:    policy_q    <= pwdata[0];
          REG_MAX_ATT:   max_att_q   <= pwdata[ATT_W-1:0];
          REG_INIT:      init_q      <= pwdata[INIT_W-1:0];
          REG_MULT:      mult_q      <= pwdata[MULT_W-1:0];
          REG_MAX_DELAY: max_delay_q <= pwdata[CD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= op_e'(in_i.opcode);
            dev_q   <= in_i.device;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          state_q <= S_IDLE;
          case (op_q)
            OP_TICK: begin
              idx_q   <= '0;
              mask_q  <= '0;
              state_q <= S_WALK;
            end
            OP_SCHEDULE, OP_RETRY: begin
              if (dev_ok && (op_q == OP_SCHEDULE || present_q[sidx])) begin
                if (op_q == OP_RETRY) begin
                  inflight_q[sidx] <= 1'b0;
                  attempt_q[sidx]  <= att_eff;
                end
                if (policy_q && !paused_q) begin
                  present_q[sidx] <= 1'b1;
                  if (!armed_q[sidx] && !inflight_eff) begin
                    if (att_eff >= max_att_q) begin
                      present_q[sidx]  <= 1'b0;
                      attempt_q[sidx]  <= '0;
                      armed_q[sidx]    <= 1'b0;
                      inflight_q[sidx] <= 1'b0;
                      pend_kind_q      <= EV_EXHAUSTED;
                      pend_att_q       <= att_eff;
                      pend_sch_q       <= 1'b0;
                      pend_prog_q      <= 1'b0;
                      state_q          <= S_EMIT;
                    end else begin
                      attempt_q[sidx] <= att_eff + 1'b1;
                      state_q         <= S_DSTART;
                    end
                  end
                end
              end
            end
            OP_CANCEL: begin
              if (dev_ok) begin
                present_q[sidx]  <= 1'b0;
                attempt_q[sidx]  <= '0;
                armed_q[sidx]    <= 1'b0;
                inflight_q[sidx] <= 1'b0;
              end
            end
            OP_CANCEL_ALL, OP_PAUSE: begin
              present_q  <= '0;
              attempt_q  <= '{default: '0};
              armed_q    <= '0;
              inflight_q <= '0;
              if (op_q == OP_PAUSE) begin
                paused_q <= 1'b1;
              end
            end
            OP_RESUME: begin
              paused_q <= 1'b0;
            end
            OP_COMPLETE: begin
              if (dev_ok && present_q[sidx]) begin
                inflight_q[sidx] <= 1'b0;
              end
            end
            OP_TERMINAL: begin
              if (dev_ok) begin
                pend_kind_q      <= EV_TERMINAL;
                pend_att_q       <= present_q[sidx] ? attempt_q[sidx] : '0;
                pend_sch_q       <= 1'b0;
                pend_prog_q      <= 1'b0;
                present_q[sidx]  <= 1'b0;
                attempt_q[sidx]  <= '0;
                armed_q[sidx]    <= 1'b0;
                inflight_q[sidx] <= 1'b0;
                state_q          <= S_EMIT;
              end
            end
            OP_QUERY: begin
              if (dev_ok) begin
                pend_kind_q <= EV_STATUS;
                pend_att_q  <= present_q[sidx] ? attempt_q[sidx] : '0;
                pend_sch_q  <= present_q[sidx] && armed_q[sidx];
                pend_prog_q <= present_q[sidx] && inflight_q[sidx];
                state_q     <= S_EMIT;
              end
            end
            default: ;
          endcase
        end

        S_DSTART: begin
          state_q <= S_DELAY;
        end

        S_DELAY: begin
          if (dly_rsp.done) begin
            armed_q[sidx] <= 1'b1;
            state_q       <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= pend_kind_q;
            out_dev_q   <= dev_q;
            out_att_q   <= pend_att_q;
            out_sch_q   <= pend_sch_q;
            out_prog_q  <= pend_prog_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_WALK: begin
          if (armed_q[idx_q] && cd_q[idx_q] <= CD_W'(1)) begin
            armed_q[idx_q]    <= 1'b0;
            inflight_q[idx_q] <= 1'b1;
            mask_q[idx_q]     <= 1'b1;
          end
          if (idx_q == LAST_SLOT) begin
            idx_q   <= '0;
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        S_DRAIN: begin
          if (mask_q == '0) begin
            state_q <= S_IDLE;
          end else if (!mask_q[idx_q]) begin
            idx_q <= idx_q + 1'b1;
          end else if (out_free) begin
            out_valid_q   <= 1'b1;
            out_kind_q    <= EV_DUE;
            out_dev_q     <= DEV_W'(idx_q);
            out_att_q     <= attempt_q[idx_q];
            out_sch_q     <= 1'b0;
            out_prog_q    <= 1'b0;
            out_last_q    <= (mask_q & ~idx_bit) == '0;
            mask_q[idx_q] <= 1'b0;
            idx_q         <= idx_q + 1'b1;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.event_kind     = out_kind_q;
  assign out_o.event_device   = out_dev_q;
  assign out_o.attempt_count  = out_att_q;
  assign out_o.is_scheduled   = out_sch_q;
  assign out_o.is_in_progress = out_prog_q;
  assign out_o.last_event     = out_last_q;

`ifndef SYNTH
  a_armed_xor_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & inflight_q) == '0)
    else $error("slot both armed and in flight");

  a_absent_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((armed_q | inflight_q) & ~present_q) == '0)
    else $error("absent slot carries flags");

  a_paused_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q |-> present_q == '0)
    else $error("slot present while paused");

  a_delay_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dly_rsp.done |-> dly_rsp.delay <= max_delay_q)
    else $error("delay above cap");

  a_due_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |-> (mask_q & ~inflight_q) == '0)
    else $error("due slot not in flight");
`endif

endmodule
